[design/nsfc_pkg.sv]
// ---------------------------------------------------------------------------
// nsfc_pkg
// Shared constants, types and helper functions for the NMEA sentence framer
// and checksum checker.
// ---------------------------------------------------------------------------
package nsfc_pkg;

    localparam int LINE_MAX   = 128;
    localparam int LINE_CNT_W = $clog2(LINE_MAX);
    localparam int HDR_CHARS  = 5;

    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_LF     = 8'h0A;

    localparam logic [23:0] KIND_GGA = 24'h474741;
    localparam logic [23:0] KIND_RMC = 24'h524D43;
    localparam logic [23:0] KIND_GSV = 24'h475356;
    localparam logic [23:0] KIND_ZDA = 24'h5A4441;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FRAMING  = 2'd1,
        ST_CHECKSUM = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        SK_OTHER = 3'd0,
        SK_GGA   = 3'd1,
        SK_RMC   = 3'd2,
        SK_GSV   = 3'd3,
        SK_ZDA   = 3'd4
    } t_kind;

    typedef logic [LINE_CNT_W-1:0] t_line_cnt;

    // Snapshot of a finished line, handed from the line tracker to the judge
    typedef struct packed {
        logic                         judge;
        logic                         star_seen;
        t_line_cnt                    star_pos;
        t_line_cnt                    line_cnt;
        logic [7:0]                   run_xor;
        logic [7:0]                   hex_val;
        logic [HDR_CHARS-1:0][7:0]    hdr;
    } t_line_end;

    // Returns {is_hex, nibble}
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end
        return r;
    endfunction

endpackage

[design/nsfc_in_stage.sv]
// ---------------------------------------------------------------------------
// nsfc_in_stage
// Input register: holds one received byte until the line tracker takes it.
// ---------------------------------------------------------------------------
module nsfc_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);
    import nsfc_pkg::*;

    logic       r_valid;
    logic [7:0] r_byte;
    logic       w_load;

    assign o_in_stall = r_valid && !i_take;
    assign w_load     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_byte <= i_rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

[design/nsfc_line_track.sv]
// ---------------------------------------------------------------------------
// nsfc_line_track
// Line state: length, overflow, star position, running XOR, hex tail and
// header characters. Flags a finished line for judging.
// ---------------------------------------------------------------------------
module nsfc_line_track (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_take,
    input  logic [7:0]           i_byte,
    output logic                 o_is_term,
    output nsfc_pkg::t_line_end  o_end
);
    import nsfc_pkg::*;

    t_line_cnt                 r_line_cnt, n_line_cnt;
    logic                      r_ovf, n_ovf;
    logic                      r_session, n_session;
    logic                      r_star_seen, n_star_seen;
    t_line_cnt                 r_star_pos, n_star_pos;
    logic [7:0]                r_xor, n_xor;
    logic [7:0]                r_hex, n_hex;
    logic                      r_hex_stop, n_hex_stop;
    logic [HDR_CHARS-1:0][7:0] r_hdr, n_hdr;
    logic [4:0]                w_digit;
    logic                      w_full;

    assign o_is_term = (i_byte == CH_CR) || (i_byte == CH_LF);
    assign w_digit   = hex_digit(i_byte);
    assign w_full    = ({1'b0, r_line_cnt} + 1'b1) >= (LINE_CNT_W+1)'(LINE_MAX);

    assign o_end.judge     = i_take && o_is_term && (r_line_cnt != '0) && !r_ovf && r_session;
    assign o_end.star_seen = r_star_seen;
    assign o_end.star_pos  = r_star_pos;
    assign o_end.line_cnt  = r_line_cnt;
    assign o_end.run_xor   = r_xor;
    assign o_end.hex_val   = r_hex;
    assign o_end.hdr       = r_hdr;

    always_comb begin
        n_line_cnt  = r_line_cnt;
        n_ovf       = r_ovf;
        n_session   = r_session;
        n_star_seen = r_star_seen;
        n_star_pos  = r_star_pos;
        n_xor       = r_xor;
        n_hex       = r_hex;
        n_hex_stop  = r_hex_stop;
        n_hdr       = r_hdr;
        if (i_take) begin
            if (i_byte == CH_DOLLAR || o_is_term) begin
                n_line_cnt  = '0;
                n_ovf       = 1'b0;
                n_star_seen = 1'b0;
                n_star_pos  = '0;
                n_xor       = 8'd0;
                n_hex       = 8'd0;
                n_hex_stop  = 1'b0;
                if (i_byte == CH_DOLLAR) begin
                    n_session = 1'b1;
                end
            end else if (w_full) begin
                n_ovf = 1'b1;
            end else begin
                for (int i = 0; i < HDR_CHARS; i++) begin
                    if (r_line_cnt == LINE_CNT_W'(i)) begin
                        n_hdr[i] = i_byte;
                    end
                end
                if (!r_star_seen) begin
                    if (i_byte == CH_STAR) begin
                        n_star_seen = 1'b1;
                        n_star_pos  = r_line_cnt;
                    end else begin
                        n_xor = r_xor ^ i_byte;
                    end
                end else if (!r_hex_stop) begin
                    if (!w_digit[4]) begin
                        n_hex_stop = 1'b1;
                    end else begin
                        n_hex = {r_hex[3:0], w_digit[3:0]};
                    end
                end
                n_line_cnt = r_line_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_cnt  <= '0;
            r_ovf       <= 1'b0;
            r_session   <= 1'b0;
            r_star_seen <= 1'b0;
            r_star_pos  <= '0;
            r_xor       <= 8'd0;
            r_hex       <= 8'd0;
            r_hex_stop  <= 1'b0;
        end else begin
            r_line_cnt  <= n_line_cnt;
            r_ovf       <= n_ovf;
            r_session   <= n_session;
            r_star_seen <= n_star_seen;
            r_star_pos  <= n_star_pos;
            r_xor       <= n_xor;
            r_hex       <= n_hex;
            r_hex_stop  <= n_hex_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
    end

endmodule

[design/nsfc_judge.sv]
// ---------------------------------------------------------------------------
// nsfc_judge
// Line verdict, sentence classification, wrapping counters and the result
// register.
// ---------------------------------------------------------------------------
module nsfc_judge (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  nsfc_pkg::t_line_end i_end,
    input  logic                i_out_stall,
    output logic                o_out_valid,
    output logic [1:0]          o_status,
    output logic [2:0]          o_sentence_kind,
    output logic [7:0]          o_talker_first,
    output logic [7:0]          o_talker_second,
    output logic [6:0]          o_payload_length,
    output logic [7:0]          o_computed_sum,
    output logic [7:0]          o_declared_sum,
    output logic [31:0]         o_good_count,
    output logic [31:0]         o_checksum_error_count,
    output logic [31:0]         o_framing_error_count
);
    import nsfc_pkg::*;

    logic         r_valid;
    t_status      r_status, n_status;
    t_kind        r_kind, n_kind;
    logic [7:0]   r_t1, n_t1, r_t2, n_t2;
    logic [6:0]   r_plen, n_plen;
    logic [7:0]   r_csum, n_csum, r_dsum, n_dsum;
    logic [31:0]  r_good, r_cerr, r_ferr;
    logic         w_framing;
    logic [23:0]  w_tag;

    assign w_framing = !i_end.star_seen ||
        (({2'b00, i_end.star_pos} + (LINE_CNT_W+2)'(3)) > {2'b00, i_end.line_cnt});
    assign w_tag = {i_end.hdr[2], i_end.hdr[3], i_end.hdr[4]};

    always_comb begin
        n_status = ST_OK;
        n_kind   = SK_OTHER;
        n_t1     = 8'd0;
        n_t2     = 8'd0;
        n_plen   = 7'd0;
        n_csum   = 8'd0;
        n_dsum   = 8'd0;
        if (w_framing) begin
            n_status = ST_FRAMING;
        end else begin
            n_plen = 7'(i_end.star_pos);
            n_csum = i_end.run_xor;
            n_dsum = i_end.hex_val;
            if (i_end.run_xor != i_end.hex_val) begin
                n_status = ST_CHECKSUM;
            end else if ({1'b0, i_end.star_pos} >= (LINE_CNT_W+1)'(HDR_CHARS)) begin
                n_t1 = i_end.hdr[0];
                n_t2 = i_end.hdr[1];
                case (w_tag)
                    KIND_GGA: n_kind = SK_GGA;
                    KIND_RMC: n_kind = SK_RMC;
                    KIND_GSV: n_kind = SK_GSV;
                    KIND_ZDA: n_kind = SK_ZDA;
                    default:  n_kind = SK_OTHER;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_good  <= 32'd0;
            r_cerr  <= 32'd0;
            r_ferr  <= 32'd0;
        end else if (i_end.judge) begin
            r_valid <= 1'b1;
            r_good  <= r_good + ((n_status == ST_OK)       ? 32'd1 : 32'd0);
            r_cerr  <= r_cerr + ((n_status == ST_CHECKSUM) ? 32'd1 : 32'd0);
            r_ferr  <= r_ferr + ((n_status == ST_FRAMING)  ? 32'd1 : 32'd0);
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_end.judge) begin
            r_status <= n_status;
            r_kind   <= n_kind;
            r_t1     <= n_t1;
            r_t2     <= n_t2;
            r_plen   <= n_plen;
            r_csum   <= n_csum;
            r_dsum   <= n_dsum;
        end
    end

    assign o_out_valid            = r_valid;
    assign o_status               = r_status;
    assign o_sentence_kind        = r_kind;
    assign o_talker_first         = r_t1;
    assign o_talker_second        = r_t2;
    assign o_payload_length       = r_plen;
    assign o_computed_sum         = r_csum;
    assign o_declared_sum         = r_dsum;
    assign o_good_count           = r_good;
    assign o_checksum_error_count = r_cerr;
    assign o_framing_error_count  = r_ferr;

endmodule

[design/nmea_sentence_framer_checker.sv]
// ---------------------------------------------------------------------------
// nmea_sentence_framer_checker
// NMEA 0183 sentence framer and checksum checker.
//
// Input channel: one received byte per request (i_in_valid / o_in_stall,
// i_rx_byte). '$' opens a line, CR or LF closes it. Lines that overflow the
// line buffer, lines closed before any '$' and empty lines give no result.
// Output channel: one request per judged line (o_out_valid / i_out_stall)
// carrying status, sentence kind, talker id, payload length, both checksums
// and the three wrapping counters after this line.
// A received byte is registered in the input register and folded into the
// line state when the line tracker takes it; the result of a terminating
// byte is registered in the result register as that byte is taken.
// Throughput: one byte per cycle while no CR or LF byte is held for a
// stalled result, set by the update of the line state between the input
// register and the result register. While a stalled result waits, other
// bytes keep flowing; a CR or LF byte is held in the input register, and
// o_in_stall rises only once that register is occupied. Reset clears line
// state (header characters apart), session flag, counters and both valid flags.
// ---------------------------------------------------------------------------
module nmea_sentence_framer_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_status,
    output logic [2:0]  o_sentence_kind,
    output logic [7:0]  o_talker_first,
    output logic [7:0]  o_talker_second,
    output logic [6:0]  o_payload_length,
    output logic [7:0]  o_computed_sum,
    output logic [7:0]  o_declared_sum,
    output logic [31:0] o_good_count,
    output logic [31:0] o_checksum_error_count,
    output logic [31:0] o_framing_error_count
);
    import nsfc_pkg::*;

    logic      w_in_valid;
    logic [7:0] w_byte;
    logic      w_take;
    logic      w_is_term;
    t_line_end w_end;

    // Hold a terminating byte only while an undelivered result blocks the slot
    assign w_take = w_in_valid && (!w_is_term || !o_out_valid || !i_out_stall);

    nsfc_in_stage u_in (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_rx_byte  (i_rx_byte),
        .i_take     (w_take),
        .o_valid    (w_in_valid),
        .o_byte     (w_byte)
    );

    nsfc_line_track u_line (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_take    (w_take),
        .i_byte    (w_byte),
        .o_is_term (w_is_term),
        .o_end     (w_end)
    );

    nsfc_judge u_judge (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_end                  (w_end),
        .i_out_stall            (i_out_stall),
        .o_out_valid            (o_out_valid),
        .o_status               (o_status),
        .o_sentence_kind        (o_sentence_kind),
        .o_talker_first         (o_talker_first),
        .o_talker_second        (o_talker_second),
        .o_payload_length       (o_payload_length),
        .o_computed_sum         (o_computed_sum),
        .o_declared_sum         (o_declared_sum),
        .o_good_count           (o_good_count),
        .o_checksum_error_count (o_checksum_error_count),
        .o_framing_error_count  (o_framing_error_count)
    );

endmodule

[design/nsfc_checker.sv]
// ---------------------------------------------------------------------------
// nsfc_checker
// Port-level checks on the sentence framer: result consistency and holding
// of a stalled result.
// ---------------------------------------------------------------------------
module nsfc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [1:0]  o_status,
    input logic [2:0]  o_sentence_kind,
    input logic [7:0]  o_talker_first,
    input logic [7:0]  o_talker_second,
    input logic [6:0]  o_payload_length,
    input logic [7:0]  o_computed_sum,
    input logic [7:0]  o_declared_sum,
    input logic [31:0] o_good_count,
    input logic [31:0] o_checksum_error_count,
    input logic [31:0] o_framing_error_count
);
    import nsfc_pkg::*;

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_status == ST_OK || o_status == ST_FRAMING ||
                         o_status == ST_CHECKSUM))
        else $error("result status code out of range");

    a_ok_sums_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_OK |-> o_computed_sum == o_declared_sum)
        else $error("accepted line with differing checksums");

    a_framing_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status == ST_FRAMING |->
            o_payload_length == 7'd0 && o_computed_sum == 8'd0 &&
            o_declared_sum == 8'd0 && o_sentence_kind == SK_OTHER)
        else $error("framing error carries payload fields");

    a_reject_unclassified: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_status != ST_OK |->
            o_sentence_kind == SK_OTHER && o_talker_first == 8'd0 &&
            o_talker_second == 8'd0)
        else $error("rejected line classified");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status) &&
            $stable(o_good_count) && $stable(o_checksum_error_count) &&
            $stable(o_framing_error_count))
        else $error("stalled result changed");

endmodule

bind nmea_sentence_framer_checker nsfc_checker u_nsfc_checker (.*);

[test/tb_nmea_sentence_framer_checker.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_nmea_sentence_framer_checker
// Feeds the NMEA sentence framer a stream of bytes: a directed list of lines
// (framing faults, checksum faults, every sentence kind, hex tail quirks,
// overflow, zero and all-ones bytes), then random sentences mixed with noise.
// A line-state model in the bench predicts each verdict, and every verdict
// the block hands out is compared field by field, in order, with the oldest
// one that is pending.
// ---------------------------------------------------------------------------
module tb_nmea_sentence_framer_checker;

    import nsfc_pkg::*;

    typedef struct packed {
        t_status     status;
        t_kind       sentence_kind;
        logic [7:0]  talker_first;
        logic [7:0]  talker_second;
        logic [6:0]  payload_length;
        logic [7:0]  computed_sum;
        logic [7:0]  declared_sum;
        logic [31:0] good_count;
        logic [31:0] checksum_error_count;
        logic [31:0] framing_error_count;
    } line_verdict_t;

    typedef struct {
        string         head;
        int            pad;
        logic [7:0]    pad_chr;
        string         tail;
        bit            pin;
        line_verdict_t want;
    } probe_t;

    localparam line_verdict_t NO_PIN = '0;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic [7:0]  i_rx_byte = 8'h00;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [1:0]  o_status;
    logic [2:0]  o_sentence_kind;
    logic [7:0]  o_talker_first;
    logic [7:0]  o_talker_second;
    logic [6:0]  o_payload_length;
    logic [7:0]  o_computed_sum;
    logic [7:0]  o_declared_sum;
    logic [31:0] o_good_count;
    logic [31:0] o_checksum_error_count;
    logic [31:0] o_framing_error_count;

    // line state of the bench model
    t_line_cnt   ln_len = '0;
    bit          ln_ovf = 1'b0;
    bit          sess_on = 1'b0;
    bit          star_hit = 1'b0;
    t_line_cnt   star_at = '0;
    logic [7:0]  xor_acc = 8'h00;
    logic [7:0]  hex_acc = 8'h00;
    bit          hex_done = 1'b0;
    logic [7:0]  hdr [HDR_CHARS] = '{default: 8'h00};
    logic [31:0] n_good = '0;
    logic [31:0] n_csum = '0;
    logic [31:0] n_frame = '0;

    line_verdict_t verdict_q [$];
    line_verdict_t due;
    probe_t        probes [22];
    int            mismatches = 0;
    int            bytes_taken = 0;
    bit            calm = 1'b0;

    nmea_sentence_framer_checker u_dut (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_in_valid             (i_in_valid),
        .o_in_stall             (o_in_stall),
        .i_rx_byte              (i_rx_byte),
        .o_out_valid            (o_out_valid),
        .i_out_stall            (i_out_stall),
        .o_status               (o_status),
        .o_sentence_kind        (o_sentence_kind),
        .o_talker_first         (o_talker_first),
        .o_talker_second        (o_talker_second),
        .o_payload_length       (o_payload_length),
        .o_computed_sum         (o_computed_sum),
        .o_declared_sum         (o_declared_sum),
        .o_good_count           (o_good_count),
        .o_checksum_error_count (o_checksum_error_count),
        .o_framing_error_count  (o_framing_error_count)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void restart_line();
        ln_len   = '0;
        ln_ovf   = 1'b0;
        star_hit = 1'b0;
        star_at  = '0;
        xor_acc  = 8'h00;
        hex_acc  = 8'h00;
        hex_done = 1'b0;
    endfunction

    function automatic bit frame_byte(input logic [7:0] c, output line_verdict_t v);
        bit judged;
        int d;
        v = '0;
        judged = 1'b0;
        if (c == CH_DOLLAR) begin
            restart_line();
            sess_on = 1'b1;
        end else if (c == CH_CR || c == CH_LF) begin
            if (ln_len != 0 && !ln_ovf && sess_on) begin
                judged = 1'b1;
                if (!star_hit || int'(star_at) + 3 > int'(ln_len)) begin
                    v.status = ST_FRAMING;
                    n_frame++;
                end else begin
                    v.payload_length = star_at;
                    v.computed_sum   = xor_acc;
                    v.declared_sum   = hex_acc;
                    if (xor_acc != hex_acc) begin
                        v.status = ST_CHECKSUM;
                        n_csum++;
                    end else begin
                        v.status = ST_OK;
                        n_good++;
                        if (star_at >= 5) begin
                            v.talker_first  = hdr[0];
                            v.talker_second = hdr[1];
                            case ({hdr[2], hdr[3], hdr[4]})
                                KIND_GGA: v.sentence_kind = SK_GGA;
                                KIND_RMC: v.sentence_kind = SK_RMC;
                                KIND_GSV: v.sentence_kind = SK_GSV;
                                KIND_ZDA: v.sentence_kind = SK_ZDA;
                                default:  v.sentence_kind = SK_OTHER;
                            endcase
                        end
                    end
                end
                v.good_count           = n_good;
                v.checksum_error_count = n_csum;
                v.framing_error_count  = n_frame;
            end
            restart_line();
        end else if (int'(ln_len) + 1 >= LINE_MAX) begin
            ln_ovf = 1'b1;
        end else begin
            if (ln_len < HDR_CHARS) hdr[ln_len] = c;
            if (!star_hit) begin
                if (c == CH_STAR) begin
                    star_hit = 1'b1;
                    star_at  = ln_len;
                end else begin
                    xor_acc ^= c;
                end
            end else if (!hex_done) begin
                if (c >= "0" && c <= "9") d = c - "0";
                else if (c >= "A" && c <= "F") d = c - "A" + 10;
                else if (c >= "a" && c <= "f") d = c - "a" + 10;
                else d = -1;
                if (d < 0) hex_done = 1'b1;
                else hex_acc = {hex_acc[3:0], 4'(d)};
            end
            ln_len++;
        end
        return judged;
    endfunction

    function automatic logic [7:0] filler_char();
        logic [7:0] ch;
        ch = ($urandom_range(9) == 0) ? 8'($urandom_range(255)) : 8'($urandom_range(8'h7E, 8'h20));
        if (ch == CH_DOLLAR || ch == CH_STAR || ch == CH_CR || ch == CH_LF) ch = ",";
        return ch;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endfunction

    task automatic push_byte(input logic [7:0] b, input bit pin, input line_verdict_t pinned);
        line_verdict_t v;
        while (!calm && $urandom_range(99) < 7) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (frame_byte(b, v)) verdict_q.push_back(pin ? pinned : v);
        bytes_taken++;
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (verdict_q.size() != 0);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (verdict_q.size() == 0) begin
                $error("verdict with no line pending: status %0d", o_status);
                mismatches++;
            end else begin
                due = verdict_q.pop_front();
                check_field("status", due.status, o_status);
                check_field("sentence_kind", due.sentence_kind, o_sentence_kind);
                check_field("talker_first", due.talker_first, o_talker_first);
                check_field("talker_second", due.talker_second, o_talker_second);
                check_field("payload_length", due.payload_length, o_payload_length);
                check_field("computed_sum", due.computed_sum, o_computed_sum);
                check_field("declared_sum", due.declared_sum, o_declared_sum);
                check_field("good_count", due.good_count, o_good_count);
                check_field("checksum_error_count", due.checksum_error_count,
                            o_checksum_error_count);
                check_field("framing_error_count", due.framing_error_count,
                            o_framing_error_count);
            end
        end
        i_out_stall <= !calm && ($urandom_range(99) < 7);
    end

    initial begin
        int          k, roll, ndig;
        logic [7:0]  sum, claim;
        logic [23:0] tag;
        logic [3:0]  nibs [$];
        logic [7:0]  burst [$];
        bit          drained_mid;
        probes = '{
            '{"GPGGA*56\r\n", 0, ",", "", 1'b0, NO_PIN},
            '{"$\r", 0, ",", "", 1'b0, NO_PIN},
            '{"$GPGGA\r", 0, ",", "", 1'b1,
              '{ST_FRAMING, SK_OTHER, 8'h00, 8'h00, 7'd0, 8'h00, 8'h00, 32'd0, 32'd0, 32'd1}},
            '{"$GPGGA*4\r", 0, ",", "", 1'b1,
              '{ST_FRAMING, SK_OTHER, 8'h00, 8'h00, 7'd0, 8'h00, 8'h00, 32'd0, 32'd0, 32'd2}},
            '{"$*\n", 0, ",", "", 1'b1,
              '{ST_FRAMING, SK_OTHER, 8'h00, 8'h00, 7'd0, 8'h00, 8'h00, 32'd0, 32'd0, 32'd3}},
            '{"$GPGGA*56\r\n", 0, ",", "", 1'b1,
              '{ST_OK, SK_GGA, "G", "P", 7'd5, 8'h56, 8'h56, 32'd1, 32'd0, 32'd3}},
            '{"$GPGGA*57\r", 0, ",", "", 1'b1,
              '{ST_CHECKSUM, SK_OTHER, 8'h00, 8'h00, 7'd5, 8'h56, 8'h57, 32'd1, 32'd1, 32'd3}},
            '{"$AB*FF\r", 0, ",", "", 1'b1,
              '{ST_CHECKSUM, SK_OTHER, 8'h00, 8'h00, 7'd2, 8'h03, 8'hFF, 32'd1, 32'd2, 32'd3}},
            '{"$AB*03\n", 0, ",", "", 1'b0, NO_PIN},
            '{"$GPRMC*4b\r", 0, ",", "", 1'b0, NO_PIN},
            '{"$GPGSV*55\r", 0, ",", "", 1'b0, NO_PIN},
            '{"$GPZDA*48\n", 0, ",", "", 1'b0, NO_PIN},
            '{"$GPGGA*156\r", 0, ",", "", 1'b0, NO_PIN},
            '{"$GPGGA*5G6\r", 0, ",", "", 1'b0, NO_PIN},
            '{"$GPG$GPGGA*56\n", 0, ",", "", 1'b0, NO_PIN},
            '{"$GPGGA", 1, 8'h00, "*56\r", 1'b0, NO_PIN},
            '{"$GPGGA\377*A9\r", 0, ",", "", 1'b0, NO_PIN},
            '{"$GPGGA", 119, ",", "*7A\r", 1'b0, NO_PIN},
            '{"$GPGGA", 120, ",", "*7A\r", 1'b0, NO_PIN},
            '{"$GPGGA", 140, ",", "*56\r\n", 1'b0, NO_PIN},
            '{"$GPGGA*\r", 0, ",", "", 1'b0, NO_PIN},
            '{"$GPGGA*56,x\r", 0, ",", "", 1'b0, NO_PIN}
        };
        drained_mid = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (probes[r]) begin
            for (k = 0; k < probes[r].head.len(); k++)
                push_byte(probes[r].head[k], probes[r].pin, probes[r].want);
            repeat (probes[r].pad) push_byte(probes[r].pad_chr, probes[r].pin, probes[r].want);
            for (k = 0; k < probes[r].tail.len(); k++)
                push_byte(probes[r].tail[k], probes[r].pin, probes[r].want);
        end
        drain_results();

        bytes_taken = 0;
        while (bytes_taken < 270) begin
            calm = bytes_taken >= 60 && bytes_taken < 200;
            if (!drained_mid && bytes_taken >= 130) begin
                drain_results();
                drained_mid = 1'b1;
            end
            burst.delete();
            roll = $urandom_range(99);
            if (roll < 12) begin
                repeat ($urandom_range(12, 1)) burst.push_back(8'($urandom_range(255)));
            end else if (roll < 15) begin
                burst.push_back(CH_DOLLAR);
                repeat ($urandom_range(140, 110)) burst.push_back(filler_char());
                burst.push_back(CH_CR);
            end else begin
                burst.push_back(CH_DOLLAR);
                if ($urandom_range(99) < 85) begin
                    case ($urandom_range(4))
                        0: tag = KIND_GGA;
                        1: tag = KIND_RMC;
                        2: tag = KIND_GSV;
                        3: tag = KIND_ZDA;
                        default: tag = {8'($urandom_range(8'h5A, 8'h41)),
                                        8'($urandom_range(8'h5A, 8'h41)),
                                        8'($urandom_range(8'h5A, 8'h41))};
                    endcase
                    repeat (2) burst.push_back(8'($urandom_range(8'h5A, 8'h41)));
                    for (k = 2; k >= 0; k--) burst.push_back(tag[8*k +: 8]);
                end
                repeat ($urandom_range(14)) burst.push_back(filler_char());
                sum = 8'h00;
                foreach (burst[j]) if (j > 0) sum ^= burst[j];
                if ($urandom_range(99) >= 8) begin
                    claim = ($urandom_range(99) < 75) ? sum : 8'($urandom_range(255));
                    roll  = $urandom_range(99);
                    ndig  = (roll < 80) ? 2 : (roll < 87) ? 3 : (roll < 94) ? 1 : 0;
                    nibs.delete();
                    if (ndig == 3) nibs.push_back(4'($urandom_range(15)));
                    if (ndig >= 2) nibs.push_back(claim[7:4]);
                    if (ndig >= 1) nibs.push_back(claim[3:0]);
                    burst.push_back(CH_STAR);
                    foreach (nibs[j])
                        burst.push_back(nibs[j] < 10 ? 8'("0" + nibs[j])
                                        : 8'(($urandom_range(1) ? "a" : "A") + nibs[j] - 10));
                end
                if ($urandom_range(99) < 10)
                    repeat ($urandom_range(4, 1)) burst.push_back(filler_char());
                case ($urandom_range(2))
                    0: burst.push_back(CH_CR);
                    1: burst.push_back(CH_LF);
                    default: begin
                        burst.push_back(CH_CR);
                        burst.push_back(CH_LF);
                    end
                endcase
            end
            foreach (burst[j]) push_byte(burst[j], 1'b0, NO_PIN);
        end
        calm = 1'b0;

        // hold until every verdict is out, then let the pipeline settle
        i_in_valid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
